// ===== design/owpg_pkg.sv =====
// Shared constants for the oncoming window progress grader.
package owpg_pkg;

  localparam int unsigned MaxPoints = 256;

  localparam int unsigned TimeW     = 40;
  localparam int unsigned ProgInW   = 21;
  localparam int unsigned ProgW     = 20;
  localparam int unsigned SumW      = 28;
  localparam int unsigned GradeW    = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 40;
  localparam int unsigned LimitW    = TimeW + 1;

  localparam logic [TimeW-1:0] SlackNs        = TimeW'(1000);
  localparam logic [TimeW-1:0] HorizonReset   = TimeW'(64'd3000000000);
  localparam logic [SumW-1:0]  ComplyReset    = SumW'(1000);
  localparam logic [SumW-1:0]  ViolateReset   = SumW'(3000);
  localparam logic [SumW-1:0]  SumMax         = {SumW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegHorizon = 2'd0;
  localparam logic [CfgIdxW-1:0] RegComply  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegViolate = 2'd2;

  localparam logic [GradeW-1:0] GradeCompliant   = 2'd0;
  localparam logic [GradeW-1:0] GradeMinor       = 2'd1;
  localparam logic [GradeW-1:0] GradeMajor       = 2'd2;
  localparam logic [GradeW-1:0] GradeUnavailable = 2'd3;

endpackage

// ===== design/oncoming_window_progress_grader.sv =====
// Top level of the oncoming window progress grader: point store, window scan and report.
//
//  Channel  | Signals                                       | Direction
//  ---------+-----------------------------------------------+----------
//  in       | in_valid_i/in_ready_o, mode, time, progress,  | input
//           | oncoming, at_intersection                     |
//  out      | out_valid_o/out_ready_i, available, max,      | output
//           | grade, overflow                               |
//  cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i              | input
//
//  An add transfer is accepted, the point memory is read once per point stored before it,
//  the last read data is summed, and the window sum is then folded into the running maximum.
//  An end transfer places the report in the output register.
//  Reset clears the count, the maximum, the overflow flag and restores the limit registers;
//  the point memory needs no clearing since only entries below the count are read.
//  A report that waits in the output register holds the input off for every item until the
//  report transfer takes place.
module oncoming_window_progress_grader #(
  parameter int unsigned MAX_POINTS = owpg_pkg::MaxPoints
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [owpg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [owpg_pkg::CfgDataW-1:0] cfg_wdata_i,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [owpg_pkg::TimeW-1:0]    time_ns_i,
  input  logic signed [owpg_pkg::ProgInW-1:0] progress_mm_i,
  input  logic                          oncoming_i,
  input  logic                          at_intersection_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          available_o,
  output logic [owpg_pkg::SumW-1:0]     max_window_mm_o,
  output logic [owpg_pkg::GradeW-1:0]   grade_o,
  output logic                          overflow_o
);
  import owpg_pkg::*;

  // Count holds 0..MAX_POINTS; the memory index needs one bit less at powers of two.
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned EntW  = TimeW + ProgW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;

  // Configuration registers.
  logic [TimeW-1:0] horizon_q;
  logic [SumW-1:0]  comply_q, violate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= HorizonReset;
      comply_q  <= ComplyReset;
      violate_q <= ViolateReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHorizon: horizon_q <= cfg_wdata_i[TimeW-1:0];
        RegComply:  comply_q  <= cfg_wdata_i[SumW-1:0];
        RegViolate: violate_q <= cfg_wdata_i[SumW-1:0];
        default: ;
      endcase
    end
  end

  // Control and working registers.
  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   scan_n_q, scan_n_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [SumW-1:0]   max_q, max_d;
  logic              drop_q, drop_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [TimeW-1:0]  t_q, t_d;
  logic [LimitW-1:0] limit_q, limit_d;

  logic              out_valid_q, out_valid_d;
  logic              avail_q, avail_d;
  logic [SumW-1:0]   omax_q, omax_d;
  logic [GradeW-1:0] grade_q, grade_d;
  logic              ovf_q, ovf_d;

  // Point memory: time and clipped progress in one word.
  logic [EntW-1:0]   mem_q [MAX_POINTS];
  logic [EntW-1:0]   rd_data_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [EntW-1:0]   mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  logic              in_xfer, out_xfer;
  logic [ProgW-1:0]  kept;
  logic [TimeW-1:0]  rd_time;
  logic [ProgW-1:0]  rd_prog;
  logic signed [LimitW:0] t_dist;
  logic              in_window;
  logic [SumW:0]     sum_add;
  logic              scan_done;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;

  // Only oncoming points outside intersections count, and negative progress counts as zero.
  assign kept = (oncoming_i && !at_intersection_i && !progress_mm_i[ProgInW-1])
              ? progress_mm_i[ProgW-1:0] : '0;

  assign rd_time = rd_data_q[EntW-1:ProgW];
  assign rd_prog = rd_data_q[ProgW-1:0];

  // A stored point later than the new one gives a negative distance and is summed.
  assign t_dist    = $signed({2'b00, t_q}) - $signed({2'b00, rd_time});
  assign in_window = t_dist <= $signed({1'b0, limit_q});
  assign sum_add   = {1'b0, sum_q} + {{(SumW-ProgW+1){1'b0}}, rd_prog};
  assign scan_done = !rd_vld_q && (rd_idx_q == scan_n_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_n_d    = scan_n_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    max_d       = max_q;
    drop_d      = drop_q;
    sum_d       = sum_q;
    t_d         = t_q;
    limit_d     = limit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    avail_d     = avail_q;
    omax_d      = omax_q;
    grade_d     = grade_q;
    ovf_d       = ovf_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[AddrW-1:0];
    mem_wdata   = {time_ns_i, kept};
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_q[AddrW-1:0];

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (mode_i) begin
            out_valid_d = 1'b1;
            if (count_q == '0) begin
              avail_d = 1'b0;
              omax_d  = '0;
              grade_d = GradeUnavailable;
              ovf_d   = 1'b0;
            end else begin
              avail_d = 1'b1;
              omax_d  = max_q;
              ovf_d   = drop_q;
              if (max_q < comply_q) begin
                grade_d = GradeCompliant;
              end else if (max_q < violate_q) begin
                grade_d = GradeMinor;
              end else begin
                grade_d = GradeMajor;
              end
            end
            count_d = '0;
            max_d   = '0;
            drop_d  = 1'b0;
          end else if (count_q >= CntW'(MAX_POINTS)) begin
            drop_d = 1'b1;
          end else begin
            // The new point is always inside its own window, so it seeds the sum.
            mem_we   = 1'b1;
            count_d  = count_q + 1'b1;
            scan_n_d = count_q;
            rd_idx_d = '0;
            sum_d    = {{(SumW-ProgW){1'b0}}, kept};
            t_d      = time_ns_i;
            limit_d  = {1'b0, horizon_q} + {1'b0, SlackNs};
            state_d  = StScan;
          end
        end
      end
      StScan: begin
        if (rd_vld_q && in_window) begin
          sum_d = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
        end
        if (rd_idx_q != scan_n_q) begin
          mem_re   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (scan_done) begin
          if (sum_q > max_q) begin
            max_d = sum_q;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      max_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      max_q       <= max_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_n_q <= scan_n_d;
    sum_q    <= sum_d;
    t_q      <= t_d;
    limit_q  <= limit_d;
    avail_q  <= avail_d;
    omax_q   <= omax_d;
    grade_q  <= grade_d;
    ovf_q    <= ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign available_o     = avail_q;
  assign max_window_mm_o = omax_q;
  assign grade_o         = grade_q;
  assign overflow_o      = ovf_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == StScan)
    else $error("read data returned outside a scan");

  a_max_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) && scan_done |=> max_q >= $past(sum_q))
    else $error("running maximum missed a window sum");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && mode_i |=> (count_q == '0) && (max_q == '0) && !drop_q && out_valid_q)
    else $error("end transfer did not clear the set");

  a_unavail_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !avail_q |-> (grade_q == GradeUnavailable) && (omax_q == '0) && !ovf_q)
    else $error("empty report carries data");
`endif

endmodule
